[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/cpf_pkg.sv]
// Package for the CRC-16 packet framer: beat types, queue command type,
// constants and the CRC byte update. No dependencies.
package cpf_pkg;

    localparam logic [15:0] START_WORD_RESET = 16'h6666;
    localparam logic [15:0] CRC_POLY         = 16'h1021;
    localparam int          QUEUE_DEPTH_DEF  = 4;
    localparam int          IDX_W            = 4;

    localparam logic [IDX_W-1:0] IDX_SW_LO   = 4'd0;
    localparam logic [IDX_W-1:0] IDX_SW_HI   = 4'd1;
    localparam logic [IDX_W-1:0] IDX_CTRL    = 4'd2;
    localparam logic [IDX_W-1:0] IDX_LEN_LO  = 4'd3;
    localparam logic [IDX_W-1:0] IDX_LEN_HI  = 4'd4;
    localparam logic [IDX_W-1:0] IDX_SEQ_LO  = 4'd5;
    localparam logic [IDX_W-1:0] IDX_SEQ_HI  = 4'd6;
    localparam logic [IDX_W-1:0] IDX_CMD     = 4'd7;
    localparam logic [IDX_W-1:0] IDX_HCRC_LO = 4'd8;
    localparam logic [IDX_W-1:0] IDX_HCRC_HI = 4'd9;
    localparam logic [IDX_W-1:0] IDX_PDATA   = 4'd0;
    localparam logic [IDX_W-1:0] IDX_PCRC_LO = 4'd1;
    localparam logic [IDX_W-1:0] IDX_PCRC_HI = 4'd2;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_PAYLOAD = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  cmd_id;
        logic        ack_req;
        logic [15:0] payload_len;
        logic [7:0]  payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       error;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_ERR,
        CMD_HDR,
        CMD_HDR_CRC,
        CMD_PAY,
        CMD_PAY_CRC
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  cmd_id;
        logic        ack_req;
        logic [15:0] payload_len;
        logic [15:0] seq;
        logic [7:0]  data;
    } cmd_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hdl/crc16_packet_framer_top.sv]
// An accepted beat is written into the command queue; the back end then registers its first output byte.
// Throughput: one output byte per cycle while a command is queued and out_stall is low;
// bytes per command: payload 1, header 8 (10 at zero length), last payload 3 with CRC.
// Input is stalled only while the command queue is full.
// Reset: sequence, byte count, open flag and CRC clear, queue empties,
// start word returns to 0x6666.
module crc16_packet_framer_top #(
    parameter int QUEUE_DEPTH = cpf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cpf_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output cpf_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    logic [15:0]   start_word_reg;
    logic          queue_full;
    logic          push;
    cpf_pkg::cmd_t push_data;
    logic          pop;
    logic          head_valid;
    cpf_pkg::cmd_t head_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg <= cpf_pkg::START_WORD_RESET;
        end else if (cfg_valid && cfg_ready)
        begin
            start_word_reg <= cfg_data;
        end
    end

    cpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_data  (push_data)
    );

    cpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    cpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_word (start_word_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

[hdl/cpf_queue.sv]
// Short command queue between front and back of the packet framer.
// Depends on cpf_pkg for the command type.
module cpf_queue #(
    parameter int DEPTH = cpf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cpf_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output cpf_pkg::cmd_t head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpf_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/cpf_front.sv]
// Front of the packet framer: accepts input beats, tracks frame state,
// classifies each beat into a queue command. Depends on cpf_pkg.
module cpf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  cpf_pkg::in_item_t in_data,
    input  logic             queue_full,
    output logic             in_stall,
    output logic             push,
    output cpf_pkg::cmd_t    push_data
);

    logic [15:0] seq_reg, seq_next;
    logic [15:0] left_reg, left_next;
    logic        open_reg, open_next;
    logic        accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept;

    always_comb
    begin
        seq_next              = seq_reg;
        left_next             = left_reg;
        open_next             = open_reg;
        push_data.kind        = cpf_pkg::CMD_ERR;
        push_data.cmd_id      = in_data.cmd_id;
        push_data.ack_req     = in_data.ack_req;
        push_data.payload_len = in_data.payload_len;
        push_data.seq         = seq_reg;
        push_data.data        = in_data.payload_byte;
        if (in_data.mode == cpf_pkg::MODE_START)
        begin
            if (!open_reg)
            begin
                seq_next = seq_reg + 16'd1;
                if (in_data.payload_len == 16'd0)
                begin
                    push_data.kind = cpf_pkg::CMD_HDR_CRC;
                end else
                begin
                    push_data.kind = cpf_pkg::CMD_HDR;
                    left_next      = in_data.payload_len;
                    open_next      = 1'b1;
                end
            end
        end else
        begin
            if (open_reg)
            begin
                if (left_reg == 16'd1)
                begin
                    push_data.kind = cpf_pkg::CMD_PAY_CRC;
                    left_next      = 16'd0;
                    open_next      = 1'b0;
                end else
                begin
                    push_data.kind = cpf_pkg::CMD_PAY;
                    left_next      = left_reg - 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            left_reg <= '0;
            open_reg <= 1'b0;
        end else if (accept)
        begin
            seq_reg  <= seq_next;
            left_reg <= left_next;
            open_reg <= open_next;
        end
    end

endmodule

[hdl/cpf_back.sv]
// Back of the packet framer: expands queue commands into output beats,
// runs the CRC-16/XMODEM and holds the output register. Depends on cpf_pkg.
module cpf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        start_word,
    input  logic               head_valid,
    input  cpf_pkg::cmd_t      head_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output cpf_pkg::out_item_t out_data
);

    logic [cpf_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]               crc_reg, crc_next;
    logic                      out_valid_reg, out_valid_next;
    cpf_pkg::out_item_t        out_data_reg;
    cpf_pkg::out_item_t        beat;
    logic                      advance;
    logic                      last;
    logic                      is_data;
    logic                      crc_restart;
    logic [15:0]               crc_base;

    assign advance   = head_valid && (!out_valid_reg || !out_stall);
    assign pop       = advance && last;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign crc_base  = crc_restart ? 16'd0 : crc_reg;

    always_comb
    begin
        beat.out_byte  = 8'h00;
        beat.frame_end = 1'b0;
        beat.error     = 1'b0;
        last           = 1'b1;
        is_data        = 1'b0;
        crc_restart    = 1'b0;
        case (head_data.kind)
            cpf_pkg::CMD_ERR:
            begin
                beat.error = 1'b1;
            end
            cpf_pkg::CMD_HDR, cpf_pkg::CMD_HDR_CRC:
            begin
                is_data     = 1'b1;
                crc_restart = (idx_reg == cpf_pkg::IDX_SW_LO);
                case (idx_reg)
                    cpf_pkg::IDX_SW_LO:   beat.out_byte = start_word[7:0];
                    cpf_pkg::IDX_SW_HI:   beat.out_byte = start_word[15:8];
                    cpf_pkg::IDX_CTRL:    beat.out_byte = {7'd0, head_data.ack_req};
                    cpf_pkg::IDX_LEN_LO:  beat.out_byte = head_data.payload_len[7:0];
                    cpf_pkg::IDX_LEN_HI:  beat.out_byte = head_data.payload_len[15:8];
                    cpf_pkg::IDX_SEQ_LO:  beat.out_byte = head_data.seq[7:0];
                    cpf_pkg::IDX_SEQ_HI:  beat.out_byte = head_data.seq[15:8];
                    cpf_pkg::IDX_CMD:     beat.out_byte = head_data.cmd_id;
                    cpf_pkg::IDX_HCRC_LO:
                    begin
                        beat.out_byte = crc_reg[7:0];
                        is_data       = 1'b0;
                    end
                    cpf_pkg::IDX_HCRC_HI:
                    begin
                        beat.out_byte  = crc_reg[15:8];
                        beat.frame_end = 1'b1;
                        is_data        = 1'b0;
                    end
                    default:
                    begin
                        beat.out_byte = 8'h00;
                        is_data       = 1'b0;
                    end
                endcase
                if (head_data.kind == cpf_pkg::CMD_HDR)
                begin
                    last = (idx_reg == cpf_pkg::IDX_CMD);
                end else
                begin
                    last = (idx_reg == cpf_pkg::IDX_HCRC_HI);
                end
            end
            cpf_pkg::CMD_PAY:
            begin
                beat.out_byte = head_data.data;
                is_data       = 1'b1;
            end
            cpf_pkg::CMD_PAY_CRC:
            begin
                last = (idx_reg == cpf_pkg::IDX_PCRC_HI);
                case (idx_reg)
                    cpf_pkg::IDX_PDATA:
                    begin
                        beat.out_byte = head_data.data;
                        is_data       = 1'b1;
                    end
                    cpf_pkg::IDX_PCRC_LO: beat.out_byte = crc_reg[7:0];
                    cpf_pkg::IDX_PCRC_HI:
                    begin
                        beat.out_byte  = crc_reg[15:8];
                        beat.frame_end = 1'b1;
                    end
                    default:              beat.out_byte = 8'h00;
                endcase
            end
            default:
            begin
                beat.error = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            idx_next       = last ? '0 : idx_reg + 1'b1;
            out_valid_next = 1'b1;
            if (is_data)
            begin
                crc_next = cpf_pkg::crc_feed(crc_base, beat.out_byte);
            end
        end else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else
        begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= beat;
        end
    end

endmodule

[hdl/cpf_checker.sv]
// Port-level checker for the packet framer, bound to the top level.
// Depends on cpf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input cpf_pkg::out_item_t out_data
);

    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled beat changed")
    `CHK_SAME(a_end_no_err, out_valid && out_data.frame_end, !out_data.error, "frame end flagged as error")
    `CHK_SAME(a_err_zero, out_valid && out_data.error, out_data.out_byte == 8'h00, "error beat carries data")

endmodule

bind crc16_packet_framer_top cpf_checker u_cpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
